### rtl/dsmfd_pkg.sv
// ----------------------------------------------------------------------------
// dsmfd_pkg: shared types and constants of the serial frame decoder
// Holds the field widths, register codes, scaling constants and the queue
// entry that carries one finished frame from the front part to the back part.
// ----------------------------------------------------------------------------
package dsmfd_pkg;

  // Field widths.
  localparam int BYTE_W = 8;
  localparam int CH_W   = 11;
  localparam int POS_W  = 5;
  localparam int ID_W   = 4;
  localparam int AUX_W  = 8;
  localparam int CNT_W  = 8;
  localparam int AXIS_W = 16;
  localparam int THR_W  = 15;

  // Byte position handling: the fade count occupies the first two bytes.
  localparam logic [POS_W-1:0] FIRST_PAIR_POS = 5'd2;
  localparam logic [POS_W-1:0] POS_MAX        = 5'd31;

  // Resolution modes.
  localparam logic MODE_11BIT = 1'b0;
  localparam logic MODE_10BIT = 1'b1;

  // Channel counts per mode.
  localparam logic [ID_W:0] CH_COUNT_11 = 5'd12;
  localparam logic [ID_W:0] CH_COUNT_10 = 5'd7;

  // Aux channels start at channel 4; the 10-bit mode only has three of them.
  localparam int AUX_BASE = 4;
  localparam int AUX_N_10 = 3;

  // Configuration port.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_AUX_THR = 2'd1;
  localparam logic [1:0] REG_BIND    = 2'd2;

  // Register reset values.
  localparam logic [CH_W-1:0]  RST_AUX_THR = 11'd1100;
  localparam logic [CNT_W-1:0] RST_BIND    = 8'd120;

  // Stick centers, kept one bit wider than a channel value.
  localparam logic [CH_W:0] CENTER_11 = 12'd1024;
  localparam logic [CH_W:0] CENTER_10 = 12'd512;

  // Offsets beyond this magnitude saturate in every output, so they are clamped.
  localparam logic [CH_W-1:0] MAG_MAX = 11'd1024;

  // Scale factor 150 * 16384 / (D * 147) as a fixed-point reciprocal with
  // RECIP_SHIFT fraction bits, truncated. The truncation error stays far below
  // the distance of any exact quotient from a rounding boundary.
  localparam int RECIP_W     = 36;
  localparam int RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_11 = 36'd17547615102;
  localparam logic [RECIP_W-1:0] RECIP_10 = 36'd35129569959;
  localparam int PROD_W = CH_W + RECIP_W;

  // Output limits.
  localparam logic [THR_W-1:0] AXIS_LIMIT = 15'd16735;
  localparam logic [THR_W-1:0] Q14_ONE    = 15'd16384;
  localparam logic [THR_W-1:0] Q14_HALF   = 15'd8192;

  // Lanes of the scaling datapath: throttle first, then roll, pitch, yaw.
  localparam int NUM_LANES = 4;
  localparam int LANE_THR  = 0;
  localparam int LANE_ROLL = 1;
  localparam int LANE_PTCH = 2;
  localparam int LANE_YAW  = 3;

  // Queue between the front and back parts; the depth is a power of two.
  localparam int QUEUE_DEPTH = 2;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic             mode;
    logic [CH_W-1:0]  aux_thr;
    logic [CNT_W-1:0] bind_frames;
  } cfg_t;

  // One finished frame: the raw stick channels plus everything already settled.
  typedef struct packed {
    logic [NUM_LANES-1:0][CH_W-1:0] ch;
    logic [AUX_W-1:0]               aux;
    logic                           bind_mode;
    logic                           rx_ready;
    logic                           mode;
  } frame_t;

endpackage

### rtl/dsmfd_front.sv
// ----------------------------------------------------------------------------
// dsmfd_front: byte parser and channel store
// Tracks the byte position, pairs high and low bytes into channel writes,
// runs the bind-safety counter and queues a frame snapshot at a good frame end.
// ----------------------------------------------------------------------------
module dsmfd_front
  import dsmfd_pkg::*;
#(
  parameter int NUM_CHANNELS    = 12,
  parameter int MAX_FRAME_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_frame_byte,
  input  logic              in_frame_last,
  output logic              push,
  output frame_t            push_data,
  input  logic              q_full
);

  localparam logic [POS_W:0] MAX_POS = (POS_W+1)'(MAX_FRAME_BYTES);
  localparam logic [ID_W:0]  NCH     = (ID_W+1)'(NUM_CHANNELS);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] hold_r, hold_nxt;
  logic              good_r, good_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              bind_r, bind_nxt;
  logic              rdy_r, rdy_nxt;
  logic [CH_W-1:0]   store_r [NUM_CHANNELS];
  logic [CH_W-1:0]   store_nxt [NUM_CHANNELS];

  logic              acc;
  logic              in_window;
  logic              take;
  logic [ID_W-1:0]   id;
  logic [CH_W-1:0]   val;
  logic              id_ok;
  logic              frame_end;
  logic [CNT_W-1:0]  cnt_inc;
  logic [AUX_W-1:0]  aux;

  // The front only waits when the queue has no room.
  assign in_stall = q_full;
  assign acc      = in_valid & ~q_full;

  // Channel bytes lie from the third byte up to the frame limit.
  assign in_window = (pos_r >= FIRST_PAIR_POS) && ({1'b0, pos_r} < MAX_POS);

  // Split the held high byte and the current low byte into id and value.
  always_comb begin
    if (cfg.mode == MODE_10BIT) begin
      id    = hold_r[5:2];
      val   = {1'b0, hold_r[1:0], in_frame_byte};
      id_ok = ({1'b0, id} < CH_COUNT_10) && ({1'b0, id} < NCH);
    end else begin
      id    = hold_r[6:3];
      val   = {hold_r[2:0], in_frame_byte};
      id_ok = ({1'b0, id} < CH_COUNT_11) && ({1'b0, id} < NCH);
    end
  end

  assign take = acc & in_window & pos_r[0] & id_ok;

  // Channel store update.
  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      store_nxt[i] = (take && (id == ID_W'(i))) ? val : store_r[i];
    end
  end

  // High byte capture, byte position and frame status.
  always_comb begin
    hold_nxt = hold_r;
    pos_nxt  = pos_r;
    good_nxt = good_r | take;
    if (acc && in_window && !pos_r[0]) begin
      hold_nxt = in_frame_byte;
    end
    if (acc) begin
      if (in_frame_last) begin
        pos_nxt  = '0;
        good_nxt = 1'b0;
      end else if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + 5'd1;
      end
    end
  end

  assign frame_end = acc & in_frame_last & (good_r | take);

  // Bind-safety counter, stepped once per good frame.
  assign cnt_inc = (cnt_r != {CNT_W{1'b1}}) ? cnt_r + 8'd1 : cnt_r;

  always_comb begin
    cnt_nxt  = cnt_r;
    bind_nxt = bind_r;
    rdy_nxt  = rdy_r;
    if (frame_end) begin
      cnt_nxt = cnt_inc;
      if (cnt_inc < cfg.bind_frames) begin
        bind_nxt = 1'b1;
      end
      if (cnt_inc > cfg.bind_frames) begin
        rdy_nxt  = 1'b1;
        bind_nxt = 1'b0;
        cnt_nxt  = cfg.bind_frames + 8'd1;
      end
    end
  end

  // Aux switches against the threshold; channels past the store read as zero.
  for (genvar g = 0; g < AUX_W; g++) begin : g_aux
    if (AUX_BASE + g < NUM_CHANNELS) begin : g_on
      assign aux[g] = (store_nxt[AUX_BASE+g] > cfg.aux_thr) &&
                      ((cfg.mode == MODE_11BIT) || (g < AUX_N_10));
    end else begin : g_off
      assign aux[g] = 1'b0;
    end
  end

  // Snapshot of the frame, taken with this item's channel write included.
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      push_data.ch[l] = store_nxt[l];
    end
    push_data.aux       = aux;
    push_data.bind_mode = bind_nxt;
    push_data.rx_ready  = rdy_nxt;
    push_data.mode      = cfg.mode;
  end

  assign push = frame_end;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      hold_r <= '0;
      good_r <= 1'b0;
      cnt_r  <= '0;
      bind_r <= 1'b0;
      rdy_r  <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      pos_r  <= pos_nxt;
      hold_r <= hold_nxt;
      good_r <= good_nxt;
      cnt_r  <= cnt_nxt;
      bind_r <= bind_nxt;
      rdy_r  <= rdy_nxt;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        store_r[i] <= store_nxt[i];
      end
    end
  end

`ifndef SYNTHESIS
  // The last byte of a frame always brings the position back to the start.
  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_frame_last |=> pos_r == '0)
    else $error("byte position not cleared after frame end");
`endif

endmodule

### rtl/dsmfd_fifo.sv
// ----------------------------------------------------------------------------
// dsmfd_fifo: frame queue between the parser and the scaling pipeline
// A small first-in first-out buffer of finished frames with full and empty.
// ----------------------------------------------------------------------------
module dsmfd_fifo
  import dsmfd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  frame_t push_data,
  input  logic   pop,
  output frame_t pop_data,
  output logic   empty,
  output logic   full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  frame_t            slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign empty    = (count_r == '0);
  assign full     = (count_r == DEPTH_C);
  assign pop_data = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  // The parser must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("frame queue overflow");

  // The pipeline must never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("frame queue underflow");
`endif

endmodule

### rtl/dsmfd_back.sv
// ----------------------------------------------------------------------------
// dsmfd_back: scaling pipeline for stick commands
// Centers and clamps each stick channel, multiplies by the fixed-point scale,
// then rounds and saturates into the Q2.14 axes and the Q1.14 throttle.
// ----------------------------------------------------------------------------
module dsmfd_back
  import dsmfd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  frame_t                   head,
  input  logic                     q_empty,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [AXIS_W-1:0] out_roll_cmd,
  output logic signed [AXIS_W-1:0] out_pitch_cmd,
  output logic signed [AXIS_W-1:0] out_yaw_cmd,
  output logic [THR_W-1:0]         out_throttle_cmd,
  output logic [AUX_W-1:0]         out_aux_bits,
  output logic                     out_bind_mode,
  output logic                     out_rx_ready
);

  localparam int DIFF_W = CH_W + 2;
  localparam logic [PROD_W-1:0] AX_HALF  = PROD_W'(1) << (RECIP_SHIFT - 1);
  localparam logic [PROD_W-1:0] THR_HALF = PROD_W'(1) << RECIP_SHIFT;
  localparam int AXQ_W = PROD_W - RECIP_SHIFT;
  localparam int THQ_W = PROD_W - RECIP_SHIFT - 1;

  // Stage 1: magnitude of the offset from center.
  logic                           s1_v_r;
  logic [NUM_LANES-1:0][CH_W-1:0] s1_mag_r, s1_mag_nxt;
  logic [NUM_LANES-1:0]           s1_neg_r, s1_neg_nxt;
  logic [AUX_W-1:0]               s1_aux_r;
  logic                           s1_bind_r, s1_rdy_r, s1_mode_r;

  // Stage 2: scaled products.
  logic                             s2_v_r;
  logic [NUM_LANES-1:0][PROD_W-1:0] s2_prod_r, s2_prod_nxt;
  logic [NUM_LANES-1:0]             s2_neg_r;
  logic [AUX_W-1:0]                 s2_aux_r;
  logic                             s2_bind_r, s2_rdy_r;

  // Output stage.
  logic                     out_v_r;
  logic signed [AXIS_W-1:0] roll_r, pitch_r, yaw_r;
  logic [THR_W-1:0]         thr_r;
  logic [AUX_W-1:0]         aux_r;
  logic                     bind_r, rdy_r;
  logic [NUM_LANES-1:0][AXIS_W-1:0] axis_nxt;
  logic [THR_W-1:0]         thr_nxt;

  logic rdy1, rdy2, rdy3;
  logic [CH_W:0] center;
  logic [RECIP_W-1:0] recip;

  // Each stage moves on when the one after it is empty or moving.
  assign rdy3 = ~out_v_r | ~out_stall;
  assign rdy2 = ~s2_v_r | rdy3;
  assign rdy1 = ~s1_v_r | rdy2;
  assign pop  = ~q_empty & rdy1;

  // Stage 1 logic: offset from center, sign and clamped magnitude.
  assign center = (head.mode == MODE_10BIT) ? CENTER_10 : CENTER_11;

  always_comb begin
    logic [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0] mag;
    for (int l = 0; l < NUM_LANES; l++) begin
      diff          = {2'b00, head.ch[l]} - {1'b0, center};
      s1_neg_nxt[l] = diff[DIFF_W-1];
      mag           = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
      s1_mag_nxt[l] = (mag > DIFF_W'(MAG_MAX)) ? MAG_MAX : mag[CH_W-1:0];
    end
  end

  // Stage 2 logic: one multiply per lane by the mode's reciprocal.
  assign recip = (s1_mode_r == MODE_10BIT) ? RECIP_10 : RECIP_11;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      s2_prod_nxt[l] = {{RECIP_W{1'b0}}, s1_mag_r[l]} * {{CH_W{1'b0}}, recip};
    end
  end

  // Output logic: round, saturate and restore the sign of each axis.
  always_comb begin
    logic [PROD_W-1:0] sum;
    logic [AXQ_W-1:0]  q;
    logic [THR_W-1:0]  sat;
    axis_nxt = '0;
    for (int l = LANE_ROLL; l <= LANE_YAW; l++) begin
      sum = s2_prod_r[l] + AX_HALF;
      q   = sum[PROD_W-1:RECIP_SHIFT];
      sat = (q > AXQ_W'(AXIS_LIMIT)) ? AXIS_LIMIT : q[THR_W-1:0];
      axis_nxt[l] = s2_neg_r[l] ? (AXIS_W'(0) - {1'b0, sat}) : {1'b0, sat};
    end
  end

  // Throttle is half the axis scale around one half, clamped to 0..1.
  always_comb begin
    logic [PROD_W-1:0] sum;
    logic [THQ_W-1:0]  t;
    logic [THQ_W:0]    up;
    sum = s2_prod_r[LANE_THR] + THR_HALF;
    t   = sum[PROD_W-1:RECIP_SHIFT+1];
    up  = {1'b0, t} + (THQ_W+1)'(Q14_HALF);
    if (s2_neg_r[LANE_THR]) begin
      thr_nxt = (t >= THQ_W'(Q14_HALF)) ? '0 : Q14_HALF - t[THR_W-1:0];
    end else begin
      thr_nxt = (up > (THQ_W+1)'(Q14_ONE)) ? Q14_ONE : up[THR_W-1:0];
    end
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_v_r <= pop;
      end
      if (rdy2) begin
        s2_v_r <= s1_v_r;
      end
      if (rdy3) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_mag_r  <= s1_mag_nxt;
      s1_neg_r  <= s1_neg_nxt;
      s1_aux_r  <= head.aux;
      s1_bind_r <= head.bind_mode;
      s1_rdy_r  <= head.rx_ready;
      s1_mode_r <= head.mode;
    end
    if (rdy2 && s1_v_r) begin
      s2_prod_r <= s2_prod_nxt;
      s2_neg_r  <= s1_neg_r;
      s2_aux_r  <= s1_aux_r;
      s2_bind_r <= s1_bind_r;
      s2_rdy_r  <= s1_rdy_r;
    end
    if (rdy3 && s2_v_r) begin
      roll_r  <= axis_nxt[LANE_ROLL];
      pitch_r <= axis_nxt[LANE_PTCH];
      yaw_r   <= axis_nxt[LANE_YAW];
      thr_r   <= thr_nxt;
      aux_r   <= s2_aux_r;
      bind_r  <= s2_bind_r;
      rdy_r   <= s2_rdy_r;
    end
  end

  assign out_valid        = out_v_r;
  assign out_roll_cmd     = roll_r;
  assign out_pitch_cmd    = pitch_r;
  assign out_yaw_cmd      = yaw_r;
  assign out_throttle_cmd = thr_r;
  assign out_aux_bits     = aux_r;
  assign out_bind_mode    = bind_r;
  assign out_rx_ready     = rdy_r;

`ifndef SYNTHESIS
  // Throttle never leaves the unit range.
  a_thr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_throttle_cmd <= Q14_ONE)
    else $error("throttle command out of range");

  // Roll stays within the axis saturation limit.
  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_roll_cmd <= $signed({1'b0, AXIS_LIMIT})) &&
                  (out_roll_cmd >= -$signed({1'b0, AXIS_LIMIT})))
    else $error("roll command out of range");
`endif

endmodule

### rtl/dsm_serial_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// dsm_serial_frame_decoder_top: serial receiver frame decoder
// Decodes radio receiver frames byte by byte into stick commands and flags.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel takes one raw frame byte per item, with in_frame_last on
//   the final byte of a frame. One item is accepted in every cycle while the
//   frame queue has room; the parser updates the channel store at once.
//   When the last byte closes a frame that wrote at least one channel, one
//   result item appears on the out_ channel; frames without a channel write
//   give no result. After the edge that accepted the last byte, the frame
//   passes the queue, the centering and clamping stage, the scaling multiply
//   and the rounding output register before its result becomes valid.
//   A good frame needs at least four bytes, so results come at most one per
//   four items and the pipeline keeps pace. While out_stall holds a result,
//   the pipeline and the two-entry frame queue fill up; in_stall rises only
//   when the queue is full, and bytes of an unfinished frame keep flowing
//   until then.
//   Reset clears the channel store, parser, bind counter, queue and pipeline
//   and loads the register defaults. The user must write the registers through
//   the APB port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module dsm_serial_frame_decoder_top
  import dsmfd_pkg::*;
#(
  parameter int NUM_CHANNELS    = 12,
  parameter int MAX_FRAME_BYTES = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Configuration port.
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_W-1:0]    paddr,
  input  logic [CFG_DATA_W-1:0]    pwdata,
  output logic [CFG_DATA_W-1:0]    prdata,
  output logic                     pready,
  // Frame bytes.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [BYTE_W-1:0]        in_frame_byte,
  input  logic                     in_frame_last,
  // Results.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [AXIS_W-1:0] out_roll_cmd,
  output logic signed [AXIS_W-1:0] out_pitch_cmd,
  output logic signed [AXIS_W-1:0] out_yaw_cmd,
  output logic [THR_W-1:0]         out_throttle_cmd,
  output logic [AUX_W-1:0]         out_aux_bits,
  output logic                     out_bind_mode,
  output logic                     out_rx_ready
);

  cfg_t   cfg_r, cfg_nxt;
  logic   cfg_wr;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_empty;
  frame_t push_data;
  frame_t head;

  // Register writes complete in the access phase; the port never waits.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_MODE:    cfg_nxt.mode        = pwdata[0];
        REG_AUX_THR: cfg_nxt.aux_thr     = pwdata[CH_W-1:0];
        REG_BIND:    cfg_nxt.bind_frames = pwdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= MODE_11BIT;
      cfg_r.aux_thr     <= RST_AUX_THR;
      cfg_r.bind_frames <= RST_BIND;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register read back.
  always_comb begin
    case (paddr[3:2])
      REG_MODE:    prdata = CFG_DATA_W'(cfg_r.mode);
      REG_AUX_THR: prdata = CFG_DATA_W'(cfg_r.aux_thr);
      REG_BIND:    prdata = CFG_DATA_W'(cfg_r.bind_frames);
      default:     prdata = '0;
    endcase
  end

  // Byte parser and channel store.
  dsmfd_front #(
    .NUM_CHANNELS    (NUM_CHANNELS),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_frame_byte (in_frame_byte),
    .in_frame_last (in_frame_last),
    .push          (push),
    .push_data     (push_data),
    .q_full        (q_full)
  );

  // Frame queue.
  dsmfd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Scaling pipeline.
  dsmfd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_empty          (q_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_roll_cmd     (out_roll_cmd),
    .out_pitch_cmd    (out_pitch_cmd),
    .out_yaw_cmd      (out_yaw_cmd),
    .out_throttle_cmd (out_throttle_cmd),
    .out_aux_bits     (out_aux_bits),
    .out_bind_mode    (out_bind_mode),
    .out_rx_ready     (out_rx_ready)
  );

endmodule
